>>> rtl/alle_pkg.sv
// alle_pkg: shared opcodes, status codes, sequencer states and the result word
// for the array linked list engine. No dependencies.
`default_nettype none

package alle_pkg;

   // fixed field widths of the request and response channels
   localparam int OPC_W  = 3;
   localparam int POS_W  = 8;
   localparam int ELEM_W = 32;
   localparam int FND_W  = 8;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 8;

   // search miss and every non-search opcode report this position
   localparam logic [FND_W-1:0] FOUND_NONE = '1;

   typedef enum logic [OPC_W-1:0] {
      OP_GET    = 3'd0,
      OP_SET    = 3'd1,
      OP_INSERT = 3'd2,
      OP_APPEND = 3'd3,
      OP_REMOVE = 3'd4,
      OP_SEARCH = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_WALK,
      S_FIX,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element_out;
      logic [FND_W-1:0]  found_position;
      status_type        status;
      logic [LEN_W-1:0]  list_length;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> rtl/alle_if.sv
// alle_req_if and alle_rsp_if: valid/ready channels of the list engine.
// Depends on alle_pkg for the field widths.
`default_nettype none

interface alle_req_if;
   import alle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OPC_W-1:0]         opcode;
   logic [POS_W-1:0]         position;
   logic signed [ELEM_W-1:0] value;

   modport source (output valid, output opcode, output position, output value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input value,
                   output ready);
endinterface

interface alle_rsp_if;
   import alle_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] element_out;
   logic signed [FND_W-1:0]  found_position;
   logic [STAT_W-1:0]        status;
   logic [LEN_W-1:0]         list_length;

   modport source (output valid, output element_out, output found_position,
                   output status, output list_length, input ready);
   modport sink   (input valid, input element_out, input found_position,
                   input status, input list_length, output ready);
endinterface

`default_nettype wire

>>> rtl/array_linked_list_engine_core.sv
// array_linked_list_engine_core: sequencer of the linked list engine and its
// two stores. Depends on alle_pkg, alle_if, alle_ram and alle_outreg.
`default_nettype none

// Positional list of DATA_WIDTH-bit values held as a singly linked chain in
// an element ram and a link ram of CAPACITY slots, with unused slots on a
// free chain. One request gives one response. Every step of a walk is one
// read of both rams, so the latency is set by that read port and grows with
// the position or, for a search, the element count; remove and insert past
// position 0 end with one more link write, and errors and unknown opcodes
// skip the walk. One request is worked at a time and the next is taken once
// the result sits in the output register. No clearing pass after reset:
// slots never allocated are tracked by a fill mark, so the block takes
// requests right away.
module array_linked_list_engine_core #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   alle_req_if.sink   req_ch,
   alle_rsp_if.source rsp_ch
);
   import alle_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = (SLOT_W > POS_W) ? SLOT_W : POS_W;
   localparam int EXT_W  = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;
   localparam logic [SLOT_W-1:0] NIL = SLOT_W'(CAPACITY);

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [DATA_WIDTH-1:0]   val_ff, val_in;
   logic [CMP_W-1:0]        target_ff, target_in;
   logic                    pos_zero_ff, pos_zero_in;
   logic [SLOT_W-1:0]       head_ff, head_in;
   logic [SLOT_W-1:0]       free_ff, free_in;
   logic [SLOT_W-1:0]       hwm_ff, hwm_in;
   logic [SLOT_W-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic [SLOT_W-1:0]       prev_ff, prev_in;
   logic [CMP_W-1:0]        idx_ff, idx_in;
   logic [SLOT_W-1:0]       nfree_ff, nfree_in;
   logic [SLOT_W-1:0]       fix_addr_ff, fix_addr_in;
   logic [SLOT_W-1:0]       fix_data_ff, fix_data_in;
   logic [ELEM_W-1:0]       res_elem_ff, res_elem_in;
   logic [FND_W-1:0]        res_found_ff, res_found_in;
   status_type              res_status_ff, res_status_in;

   logic [ADDR_W-1:0]       rd_addr;
   logic                    link_we;
   logic [ADDR_W-1:0]       link_waddr;
   logic [SLOT_W-1:0]       link_wdata;
   logic [SLOT_W-1:0]       link_rdata;
   logic                    elem_we;
   logic [ADDR_W-1:0]       elem_waddr;
   logic [DATA_WIDTH-1:0]   elem_wdata;
   logic [DATA_WIDTH-1:0]   elem_rdata;

   logic                    out_load;
   logic                    out_free;
   rsp_word_type            out_word;

   op_type                  req_op;
   logic [CMP_W-1:0]        pos_cmp;
   logic [CMP_W-1:0]        cnt_cmp;
   logic [CMP_W-1:0]        ins_pos;
   logic [EXT_W-1:0]        value_wide;
   logic [EXT_W-1:0]        elem_wide;
   logic [SLOT_W-1:0]       next_free;
   logic                    fresh_new;

   assign req_op     = op_type'(req_ch.opcode);
   assign pos_cmp    = CMP_W'(req_ch.position);
   assign cnt_cmp    = CMP_W'(count_ff);
   assign ins_pos    = (req_op == OP_APPEND) ? cnt_cmp : pos_cmp;
   assign value_wide = EXT_W'(unsigned'(req_ch.value));
   assign elem_wide  = EXT_W'(signed'(elem_rdata));
   // the free chain ends in the never-allocated slots, which link to i+1
   assign fresh_new  = (free_ff == hwm_ff);
   assign next_free  = fresh_new ? (free_ff + SLOT_W'(1)) : link_rdata;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      target_in     = target_ff;
      pos_zero_in   = pos_zero_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      hwm_in        = hwm_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      nfree_in      = nfree_ff;
      fix_addr_in   = fix_addr_ff;
      fix_data_in   = fix_data_ff;
      res_elem_in   = res_elem_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rd_addr       = head_ff[ADDR_W-1:0];
      link_we       = 1'b0;
      link_waddr    = cur_ff[ADDR_W-1:0];
      link_wdata    = free_ff;
      elem_we       = 1'b0;
      elem_waddr    = cur_ff[ADDR_W-1:0];
      elem_wdata    = val_ff;
      out_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_op;
               val_in        = value_wide[DATA_WIDTH-1:0];
               res_elem_in   = '0;
               res_found_in  = FOUND_NONE;
               res_status_in = ST_OK;
               cur_in        = head_ff;
               prev_in       = NIL;
               idx_in        = '0;
               state_in      = S_DONE;
               unique case (req_op)
                  OP_GET, OP_SET, OP_REMOVE: begin
                     target_in = pos_cmp;
                     if (pos_cmp >= cnt_cmp) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        rd_addr  = head_ff[ADDR_W-1:0];
                        state_in = S_WALK;
                     end
                  end
                  OP_INSERT, OP_APPEND: begin
                     target_in   = ins_pos - CMP_W'(1);
                     pos_zero_in = (ins_pos == '0);
                     if (ins_pos > cnt_cmp) begin
                        res_status_in = ST_RANGE;
                     end else if (free_ff == NIL) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // fetch the link of the slot about to be taken
                        rd_addr  = free_ff[ADDR_W-1:0];
                        state_in = S_FREE;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff != '0) begin
                        rd_addr  = head_ff[ADDR_W-1:0];
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FREE: begin
            if (pos_zero_ff) begin
               link_we    = 1'b1;
               link_waddr = free_ff[ADDR_W-1:0];
               link_wdata = head_ff;
               elem_we    = 1'b1;
               elem_waddr = free_ff[ADDR_W-1:0];
               head_in    = free_ff;
               free_in    = next_free;
               count_in   = count_ff + SLOT_W'(1);
               if (fresh_new) begin
                  hwm_in = hwm_ff + SLOT_W'(1);
               end
               state_in = S_DONE;
            end else begin
               nfree_in = next_free;
               rd_addr  = head_ff[ADDR_W-1:0];
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            // rdata holds link and element of cur_ff this cycle
            if (op_ff == OP_SEARCH) begin
               if (elem_rdata == val_ff) begin
                  res_found_in = idx_ff[FND_W-1:0];
                  state_in     = S_DONE;
               end else if ((idx_ff + CMP_W'(1)) == cnt_cmp) begin
                  state_in = S_DONE;
               end else begin
                  rd_addr = link_rdata[ADDR_W-1:0];
                  cur_in  = link_rdata;
                  prev_in = cur_ff;
                  idx_in  = idx_ff + CMP_W'(1);
               end
            end else if (idx_ff != target_ff) begin
               rd_addr = link_rdata[ADDR_W-1:0];
               cur_in  = link_rdata;
               prev_in = cur_ff;
               idx_in  = idx_ff + CMP_W'(1);
            end else begin
               priority case (op_ff)
                  OP_GET: begin
                     res_elem_in = elem_wide[ELEM_W-1:0];
                     state_in    = S_DONE;
                  end
                  OP_SET: begin
                     res_elem_in = elem_wide[ELEM_W-1:0];
                     elem_we     = 1'b1;
                     state_in    = S_DONE;
                  end
                  OP_REMOVE: begin
                     res_elem_in = elem_wide[ELEM_W-1:0];
                     free_in     = cur_ff;
                     count_in    = count_ff - SLOT_W'(1);
                     if (prev_ff == NIL) begin
                        head_in  = link_rdata;
                        link_we  = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        // unlink now, push the slot on the free chain next
                        link_we     = 1'b1;
                        link_waddr  = prev_ff[ADDR_W-1:0];
                        link_wdata  = link_rdata;
                        fix_addr_in = cur_ff;
                        fix_data_in = free_ff;
                        state_in    = S_FIX;
                     end
                  end
                  default: begin
                     // insert after cur_ff
                     link_we     = 1'b1;
                     link_wdata  = free_ff;
                     elem_we     = 1'b1;
                     elem_waddr  = free_ff[ADDR_W-1:0];
                     fix_addr_in = free_ff;
                     fix_data_in = link_rdata;
                     free_in     = nfree_ff;
                     count_in    = count_ff + SLOT_W'(1);
                     if (fresh_new) begin
                        hwm_in = hwm_ff + SLOT_W'(1);
                     end
                     state_in = S_FIX;
                  end
               endcase
            end
         end

         S_FIX: begin
            link_we    = 1'b1;
            link_waddr = fix_addr_ff[ADDR_W-1:0];
            link_wdata = fix_data_ff;
            state_in   = S_DONE;
         end

         S_DONE: begin
            // all writes are done before the next request issues its read
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         free_ff  <= '0;
         hwm_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         hwm_ff   <= hwm_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      target_ff     <= target_in;
      pos_zero_ff   <= pos_zero_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      idx_ff        <= idx_in;
      nfree_ff      <= nfree_in;
      fix_addr_ff   <= fix_addr_in;
      fix_data_ff   <= fix_data_in;
      res_elem_ff   <= res_elem_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
   end

   alle_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   alle_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (elem_waddr),
      .wdata (elem_wdata),
      .raddr (rd_addr),
      .rdata (elem_rdata)
   );

   assign out_word = '{
      element_out:    res_elem_ff,
      found_position: res_found_ff,
      status:         res_status_ff,
      list_length:    LEN_W'(count_ff)
   };

   alle_outreg u_outreg (
      .clock  (clock),
      .reset  (reset),
      .load   (out_load),
      .word_i (out_word),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL)
      else $error("element count above capacity");

   a_empty_head : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NIL))
      else $error("list head and element count disagree");

   a_full_free : assert property (@(posedge clock) disable iff (reset)
      (free_ff == NIL) == (count_ff == NIL))
      else $error("free chain and element count disagree");

   a_free_mark : assert property (@(posedge clock) disable iff (reset)
      free_ff <= hwm_ff)
      else $error("free head beyond the fill mark");
`endif

endmodule

`default_nettype wire

>>> rtl/alle_ram.sv
// alle_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
`default_nettype none

module alle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> rtl/alle_outreg.sv
// alle_outreg: output register between the sequencer and the response channel.
// Depends on alle_pkg and alle_rsp_if.
`default_nettype none

module alle_outreg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire alle_pkg::rsp_word_type word_i,
   output      logic                  free,
   alle_rsp_if.source                 rsp_ch
);
   import alle_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // the register frees up in the same cycle its word is taken
   assign free     = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_i;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.element_out    = word_ff.element_out;
   assign rsp_ch.found_position = word_ff.found_position;
   assign rsp_ch.status         = word_ff.status;
   assign rsp_ch.list_length    = word_ff.list_length;

`ifndef SYNTHESIS
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("output word loaded while the register is still full");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded word not presented");

   a_taken_clears : assert property (@(posedge clock) disable iff (reset)
      (!load && valid_ff && rsp_ch.ready) |=> !valid_ff)
      else $error("taken word still presented");
`endif

endmodule

`default_nettype wire
